[rtl/fed_pkg.sv]
// ---------------------------------------------------------------------------
// fed_pkg
// Types, constants and helpers for the feedback echo delay.
// ---------------------------------------------------------------------------
package fed_pkg;

  typedef logic signed [23:0] sample_t;

  // configuration register indexes
  typedef enum logic [0:0] {
    CFG_MIX_AMOUNT   = 1'b0,
    CFG_DELAY_LENGTH = 1'b1
  } cfg_reg_t;

  localparam logic [15:0] MIX_FULL      = 16'd32768;
  localparam logic [15:0] BYPASS_LEVEL  = 16'd3;
  localparam logic [15:0] DELAY_RESET   = 16'd16800;
  localparam int          FEEDBACK_Q15  = 11469;
  localparam int          S24_MAX       = 8388607;
  localparam int          S24_MIN       = -8388608;

  function automatic sample_t sat_s24(input logic signed [26:0] v);
    sample_t r;
    if (v > 27'sd8388607) begin
      r = 24'(S24_MAX);
    end else if (v < -27'sd8388608) begin
      r = 24'(S24_MIN);
    end else begin
      r = 24'(v);
    end
    return r;
  endfunction

endpackage

[rtl/feedback_echo_delay.sv]
// ---------------------------------------------------------------------------
// feedback_echo_delay
// Per-channel feedback echo with a shared sample memory.
// ---------------------------------------------------------------------------
// Takes one sample per clock while in_tready is high. The synchronous memory
// read happens at the accepting edge; the blend and write-back happen as the
// processing stage advances. Every request gives one result. Sustained rate
// is one request per cycle without result-side stalls, set by the single read
// and single write port of the echo memory; a one-deep forward path covers a
// write-back that lands on the address being read. After reset, and after
// every delay_length write, in_tready stays low while the delay is reduced
// modulo the line depth. Memory contents need no clearing pass: a per-channel
// wrap flag makes unwritten entries read as zero.
module feedback_echo_delay
  import fed_pkg::*;
#(
  parameter int LINE_DEPTH = 65536,
  parameter int CHANNELS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  input  logic [0:0]  in_tuser,   // [0] channel
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [23:0] sample_out
  output logic [0:0]  out_tuser   // [0] channel_out
);

  localparam int NCH    = (CHANNELS < 2) ? CHANNELS : 2;
  localparam int AW     = $clog2(LINE_DEPTH);
  localparam int MDEPTH = NCH * LINE_DEPTH;
  localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
  localparam int K      = 16 + $clog2(LINE_DEPTH);
  localparam int PW     = K + 16;
  localparam int LW     = $clog2(LINE_DEPTH + 1);
  localparam int QW     = 16 + LW;
  localparam longint RECIP = ((64'd1 << K) + LINE_DEPTH - 1) / LINE_DEPTH;
  localparam logic [17:0] RECIP_V = 18'(RECIP);

  // configuration
  logic [15:0]   mix_r;
  logic          bypass_r;
  logic [15:0]   dl_r;
  logic [PW-1:0] prod_r;
  logic [QW-1:0] qld_r;
  logic [AW-1:0] dl_mod_r;
  logic [1:0]    busy_cnt_r;

  logic [15:0]   mix_sat;
  logic [15:0]   dl_q;
  logic [QW-1:0] dl_rem;

  // per-channel write position and wrap flag
  logic [AW-1:0] wp_r   [2];
  logic          wrap_r [2];

  // processing stage
  logic           a_vld_r;
  logic           a_act_r;
  logic           a_ch_r;
  sample_t        a_x_r;
  logic [MAW-1:0] a_wa_r;
  logic           a_rok_r;
  logic           hit_r;
  sample_t        fwd_r;
  sample_t        rd_r;

  // result register
  logic           out_vld_r;
  logic           out_ch_r;
  sample_t        out_y_r;

  sample_t mem [MDEPTH];

  // request-side signals
  logic           in_ch;
  sample_t        in_x;
  logic           ch_ok;
  logic           acc;
  logic           a_adv;
  logic           mem_we;
  logic [AW-1:0]  wp;
  logic [AW-1:0]  wp_nxt;
  logic [AW:0]    rp_wrap;
  logic [AW-1:0]  rp;
  logic [MAW-1:0] base;
  logic [MAW-1:0] ra;
  logic [MAW-1:0] wa;
  logic           act;
  logic           rok;

  // arithmetic
  sample_t              d;
  logic signed [38:0]   fb_p;
  logic signed [26:0]   st_sum;
  sample_t              st_val;
  logic signed [24:0]   diff;
  logic signed [41:0]   mix_p;
  logic signed [26:0]   y_sum;
  sample_t              y;

  assign in_ch = in_tuser[0];
  assign in_x  = sample_t'(in_tdata);
  assign ch_ok = (32'(in_ch) < CHANNELS);

  assign mix_sat = (cfg_data > MIX_FULL) ? MIX_FULL : cfg_data;

  // delay mod LINE_DEPTH through an exact reciprocal multiply
  assign dl_q   = prod_r[PW-1:K];
  assign dl_rem = QW'(dl_r) - qld_r;

  assign a_adv     = !out_vld_r || out_tready;
  assign in_tready = (!a_vld_r || a_adv) && (busy_cnt_r == 2'd0);
  assign acc       = in_tvalid && in_tready;
  assign mem_we    = a_vld_r && a_act_r && a_adv;

  always_comb begin
    wp      = wp_r[in_ch];
    wp_nxt  = (32'(wp) == LINE_DEPTH - 1) ? '0 : AW'(wp + 1'b1);
    rp_wrap = {1'b0, wp} + (AW+1)'(LINE_DEPTH) - {1'b0, dl_mod_r};
    rp      = (wp >= dl_mod_r) ? AW'(wp - dl_mod_r) : AW'(rp_wrap);
    base    = (in_ch && NCH > 1) ? MAW'(LINE_DEPTH) : '0;
    ra      = base + MAW'(rp);
    wa      = base + MAW'(wp);
    act     = !bypass_r && ch_ok;
    rok     = wrap_r[in_ch] || (rp < wp);
  end

  always_comb begin
    if (!a_rok_r) begin
      d = '0;
    end else if (hit_r) begin
      d = fwd_r;
    end else begin
      d = rd_r;
    end
    fb_p   = 39'(d) * 39'sd11469;
    st_sum = 27'(a_x_r) + 27'(fb_p >>> 15);
    st_val = sat_s24(st_sum);
    diff   = 25'(d) - 25'(a_x_r);
    mix_p  = 42'(diff) * $signed({26'b0, mix_r});
    y_sum  = 27'(a_x_r) + 27'(mix_p >>> 15);
    y      = a_act_r ? sat_s24(y_sum) : a_x_r;
  end

  // configuration and delay reduction
  always_ff @(posedge clk) begin
    prod_r <= PW'(dl_r) * PW'(RECIP_V);
    qld_r  <= QW'(dl_q) * QW'(LINE_DEPTH);
    if (dl_rem >= QW'(LINE_DEPTH)) begin
      dl_mod_r <= AW'(dl_rem - QW'(LINE_DEPTH));
    end else begin
      dl_mod_r <= AW'(dl_rem);
    end
    if (!rst_n) begin
      mix_r      <= '0;
      bypass_r   <= 1'b1;
      dl_r       <= DELAY_RESET;
      busy_cnt_r <= 2'd3;
    end else begin
      if (busy_cnt_r != 2'd0) begin
        busy_cnt_r <= busy_cnt_r - 2'd1;
      end
      if (cfg_wr_en) begin
        unique case (cfg_reg_t'(cfg_index))
          CFG_MIX_AMOUNT: begin
            mix_r    <= mix_sat;
            bypass_r <= (mix_sat <= BYPASS_LEVEL);
          end
          CFG_DELAY_LENGTH: begin
            dl_r       <= cfg_data;
            busy_cnt_r <= 2'd3;
          end
          default: ;
        endcase
      end
    end
  end

  // write positions and pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r[0]   <= '0;
      wp_r[1]   <= '0;
      wrap_r[0] <= 1'b0;
      wrap_r[1] <= 1'b0;
      a_vld_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (acc && act) begin
        wp_r[in_ch] <= wp_nxt;
        if (wp_nxt == '0) begin
          wrap_r[in_ch] <= 1'b1;
        end
      end
      if (acc) begin
        a_vld_r <= 1'b1;
      end else if (a_adv) begin
        a_vld_r <= 1'b0;
      end
      if (a_adv) begin
        out_vld_r <= a_vld_r;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (acc) begin
      a_act_r <= act;
      a_ch_r  <= in_ch;
      a_x_r   <= in_x;
      a_wa_r  <= wa;
      a_rok_r <= rok;
      // write-back lands on the address being read this cycle
      hit_r   <= mem_we && (a_wa_r == ra);
      fwd_r   <= st_val;
    end
    if (a_adv && a_vld_r) begin
      out_ch_r <= a_ch_r;
      out_y_r  <= y;
    end
  end

  // echo memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[a_wa_r] <= st_val;
    end
    if (acc) begin
      rd_r <= mem[ra];
    end
  end

  assign out_tvalid   = out_vld_r;
  assign out_tdata    = out_y_r;
  assign out_tuser[0] = out_ch_r;

endmodule

[sim/fed_checker.sv]
// ---------------------------------------------------------------------------
// fed_checker
// Watches the configuration port and both streams of the echo delay, keeps
// its own copy of the echo lines and write positions, and checks every
// result against the oldest prediction in order.
// ---------------------------------------------------------------------------
module fed_checker
  import fed_pkg::*;
#(
  parameter int LINE_DEPTH = 65536,
  parameter int CHANNELS   = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] sample_in
  input  logic [0:0]  in_tuser,   // [0] channel
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // [23:0] sample_out
  input  logic [0:0]  out_tuser,  // [0] channel_out
  output int          mismatches,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [0:0] channel;
    sample_t    sample;
  } echo_result_t;

  sample_t      echo_line [CHANNELS][LINE_DEPTH];
  int unsigned  wr_pos [CHANNELS];
  logic [15:0]  mix_reg;
  logic [15:0]  delay_reg;
  echo_result_t blend_q[$];
  int           fail_count;

  function automatic sample_t clamp24(input longint v);
    if (v > S24_MAX) return sample_t'(S24_MAX);
    if (v < S24_MIN) return sample_t'(S24_MIN);
    return sample_t'(v);
  endfunction

  // Blend one sample and update the echo line of its channel.
  function automatic echo_result_t echo_blend(input logic [0:0] ch, input sample_t x);
    echo_result_t r;
    longint       m;
    longint       d;
    longint       xv;
    int unsigned  c;
    int unsigned  wp;
    int unsigned  dl;
    int unsigned  rp;
    c  = ch;
    xv = x;
    m  = (mix_reg > MIX_FULL) ? MIX_FULL : mix_reg;
    r.channel = ch;
    r.sample  = x;
    if (m > BYPASS_LEVEL && c < CHANNELS) begin
      wp = wr_pos[c];
      dl = delay_reg % LINE_DEPTH;
      // delay 0 reads the entry about to be overwritten
      rp = (wp + LINE_DEPTH - dl) % LINE_DEPTH;
      d  = echo_line[c][rp];
      echo_line[c][wp] = clamp24(xv + ((d * FEEDBACK_Q15) >>> 15));
      wr_pos[c] = (wp + 1) % LINE_DEPTH;
      r.sample = clamp24(xv + (((d - xv) * m) >>> 15));
    end
    return r;
  endfunction

  always @(posedge clk) begin : track
    echo_result_t want;
    echo_result_t got;
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wr_pos[c] = 0;
        for (int i = 0; i < LINE_DEPTH; i++) echo_line[c][i] = '0;
      end
      mix_reg    = '0;
      delay_reg  = DELAY_RESET;
      fail_count = 0;
      blend_q.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_MIX_AMOUNT) begin
          mix_reg = cfg_data;
        end else if (cfg_index == CFG_DELAY_LENGTH) begin
          delay_reg = cfg_data;
        end
      end
      if (in_tvalid && in_tready) begin
        blend_q.push_back(echo_blend(in_tuser, sample_t'(in_tdata)));
      end
      if (out_tvalid && out_tready) begin
        got.channel = out_tuser;
        got.sample  = sample_t'(out_tdata);
        if (blend_q.size() == 0) begin
          if (fail_count < 10) begin
            $display("%0t: unexpected result ch %0d sample %0d",
                     $realtime, got.channel, got.sample);
          end
          fail_count++;
        end else begin
          want = blend_q.pop_front();
          if (got.channel !== want.channel || got.sample !== want.sample) begin
            if (fail_count < 10) begin
              $display("%0t: result mismatch: expected ch %0d sample %0d, got ch %0d sample %0d",
                       $realtime, want.channel, want.sample, got.channel, got.sample);
            end
            fail_count++;
          end
        end
      end
    end
    mismatches <= fail_count;
    pending    <= blend_q.size();
  end

endmodule

[sim/tb_feedback_echo_delay.sv]
// ---------------------------------------------------------------------------
// tb_feedback_echo_delay
// Stimulus and verdict for the feedback echo delay.
// ---------------------------------------------------------------------------
// Directed requests cover bypass, the mix and delay extremes and feedback
// saturation on both channels; then random phases, each with its own mix,
// delay and idling pattern, stream samples through. Checking is done by
// fed_checker, which hands back its failure count.
module tb_feedback_echo_delay;
  timeunit 1ns;
  timeprecision 1ps;
  import fed_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 8;
  localparam int PHASE_REQS  = 225;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_wr_en  = 1'b0;
  logic [0:0]  cfg_index  = CFG_MIX_AMOUNT;
  logic [15:0] cfg_data   = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;  // [23:0] sample_in
  logic [0:0]  in_tuser   = '0;  // [0] channel
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;        // [23:0] sample_out
  logic [0:0]  out_tuser;        // [0] channel_out

  int   mismatches;
  int   pending;
  int   cycle_count = 0;
  logic in_idle     = 1'b1;
  logic out_idle    = 1'b1;

  always #5ns clk = ~clk;

  feedback_echo_delay uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  fed_checker echo_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .pending    (pending)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result side: random stall before each result, none when out_idle is low
  initial begin : result_sink
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = out_idle ? $urandom_range(0, 15) : 0;
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  task automatic send_sample(input logic [0:0] ch, input sample_t s);
    int gap;
    gap = in_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tuser  <= ch;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // stop requesting until every result is back, then let the pipe empty
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  function automatic sample_t random_sample();
    case ($urandom_range(0, 9))
      0: return sample_t'(S24_MAX);
      1: return sample_t'(S24_MIN);
      2: return sample_t'(int'($urandom_range(0, 511)) - 256);
      3: return sample_t'(int'($urandom_range(0, 131071)) - 65536);
      default: return sample_t'($urandom());
    endcase
  endfunction

  function automatic logic [15:0] random_mix();
    case ($urandom_range(0, 7))
      0: return 16'($urandom_range(0, 3));
      1: return MIX_FULL;
      2: return 16'($urandom_range(32769, 65535));
      default: return 16'($urandom_range(4, 32768));
    endcase
  endfunction

  // mostly short delays so the echo feeds back within a phase
  function automatic logic [15:0] random_delay();
    case ($urandom_range(0, 9))
      0: return 16'd0;
      1: return 16'hFFFF;
      2: return 16'($urandom());
      3: return 16'($urandom_range(49, 200));
      default: return 16'($urandom_range(1, 48));
    endcase
  endfunction

  initial begin : stimulus
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset config: mix 0 is bypass
    send_sample(1'b0, sample_t'(S24_MAX));
    send_sample(1'b1, sample_t'(S24_MIN));
    send_sample(1'b0, sample_t'(0));
    send_sample(1'b1, sample_t'(-1));

    // highest bypass level
    drain();
    write_reg(CFG_MIX_AMOUNT, BYPASS_LEVEL);
    write_reg(CFG_DELAY_LENGTH, 16'd1);
    send_sample(1'b0, sample_t'(24'h123456));
    send_sample(1'b0, sample_t'(-5));

    // full wet, delay 1: repeated extremes drive the stored value into saturation
    drain();
    write_reg(CFG_MIX_AMOUNT, MIX_FULL);
    for (int i = 0; i < 3; i++) begin
      send_sample(1'b0, sample_t'(S24_MAX));
      send_sample(1'b1, sample_t'(S24_MIN));
    end
    send_sample(1'b0, sample_t'(0));
    send_sample(1'b1, sample_t'(0));

    // mix above full saturates; delay 0 reads the entry being replaced
    drain();
    write_reg(CFG_MIX_AMOUNT, 16'hFFFF);
    write_reg(CFG_DELAY_LENGTH, 16'd0);
    send_sample(1'b0, sample_t'(1000));
    send_sample(1'b1, sample_t'(-1000));
    send_sample(1'b0, sample_t'(S24_MIN));
    send_sample(1'b1, sample_t'(S24_MAX));

    // lowest active mix, longest delay
    drain();
    write_reg(CFG_MIX_AMOUNT, 16'd4);
    write_reg(CFG_DELAY_LENGTH, 16'hFFFF);
    send_sample(1'b0, sample_t'(S24_MAX));
    send_sample(1'b1, sample_t'(S24_MIN));
    send_sample(1'b0, sample_t'(-1));

    for (int ph = 0; ph < PHASES; ph++) begin
      drain();
      in_idle  = ph[0];
      out_idle = ph[1];
      write_reg(CFG_MIX_AMOUNT, random_mix());
      write_reg(CFG_DELAY_LENGTH, random_delay());
      repeat (PHASE_REQS) send_sample(1'($urandom_range(0, 1)), random_sample());
    end

    drain();
    repeat (8) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
